>>> design/wwmc_pkg.sv
// ----------------------------------------------------------------------------
// wwmc_pkg
// Shared types, constants and the byte compare for the whole-word match counter.
// ----------------------------------------------------------------------------
package wwmc_pkg;

    localparam int MAX_WORD_DEF      = 32;
    localparam int POSITION_BITS_DEF = 20;
    localparam int FIELD_BITS        = 20;
    localparam int PLEN_BITS         = 6;

    localparam logic [FIELD_BITS-1:0] COUNT_MAX  = {FIELD_BITS{1'b1}};
    localparam logic [7:0]            SPACE_CHAR = 8'd32;
    localparam logic [7:0]            FOLD_STEP  = 8'd32;
    localparam logic [PLEN_BITS-1:0]  PLEN_RESET = 6'd1;

    // register index of pattern_length
    localparam logic REG_PATTERN_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_TEXT = 2'd1,
        ACT_END  = 2'd2
    } action_t;

    // item handed from the read stage to the scan stage
    typedef struct packed {
        logic       is_text;
        logic       is_end;
        logic       first_byte;
        logic       force_miss;
        logic       len_ok;
        logic [7:0] char_code;
    } scan_item_t;

    // equal when the bytes differ by 0, 32 or -32
    function automatic logic bytes_alike(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] ax;
        logic [8:0] bx;
        begin
            ax = {1'b0, a};
            bx = {1'b0, b};
            bytes_alike = (ax == bx) || (ax == bx + {1'b0, FOLD_STEP})
                          || (bx == ax + {1'b0, FOLD_STEP});
        end
    endfunction

endpackage

>>> design/wwmc_pattern_mem.sv
// ----------------------------------------------------------------------------
// wwmc_pattern_mem
// Pattern byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wwmc_pattern_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/wwmc_scan.sv
// ----------------------------------------------------------------------------
// wwmc_scan
// Scan stage: compares against the stored byte, closes words, counts hits and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module wwmc_scan
    import wwmc_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  scan_item_t            item,
    input  logic [7:0]            pattern_byte,
    output logic                  hold,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  found,
    output logic [FIELD_BITS-1:0] match_total,
    output logic [FIELD_BITS-1:0] first_start
);

    logic [POSITION_BITS-1:0] text_pos_reg,    text_pos_next;
    logic [POSITION_BITS-1:0] word_begin_reg,  word_begin_next;
    logic [POSITION_BITS-1:0] first_hit_reg,   first_hit_next;
    logic [FIELD_BITS-1:0]    hit_count_reg,   hit_count_next;
    logic                     still_reg,       still_next;
    logic                     any_hit_reg,     any_hit_next;
    logic                     out_valid_reg,   out_valid_next;
    logic                     found_reg,       found_next;
    logic [FIELD_BITS-1:0]    total_reg,       total_next;
    logic [FIELD_BITS-1:0]    start_reg,       start_next;

    logic                     advance;
    logic                     hit;
    logic [FIELD_BITS-1:0]    count_closed;
    logic                     any_closed;
    logic [POSITION_BITS-1:0] first_closed;

    assign hold    = out_valid_reg && !out_ready && item.is_end;
    assign advance = item_valid && !hold;

    always_comb
    begin
        hit          = still_reg && item.len_ok;
        count_closed = hit_count_reg;
        any_closed   = any_hit_reg;
        first_closed = first_hit_reg;
        if (hit)
        begin
            if (hit_count_reg != COUNT_MAX)
            begin
                count_closed = hit_count_reg + 1'b1;
            end
            if (!any_hit_reg)
            begin
                any_closed   = 1'b1;
                first_closed = word_begin_reg;
            end
        end

        text_pos_next   = text_pos_reg;
        word_begin_next = word_begin_reg;
        first_hit_next  = first_hit_reg;
        hit_count_next  = hit_count_reg;
        still_next      = still_reg;
        any_hit_next    = any_hit_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        found_next      = found_reg;
        total_next      = total_reg;
        start_next      = start_reg;

        if (advance && item.is_text)
        begin
            text_pos_next = text_pos_reg + 1'b1;
            if (item.char_code == SPACE_CHAR)
            begin
                hit_count_next = count_closed;
                any_hit_next   = any_closed;
                first_hit_next = first_closed;
                still_next     = 1'b1;
            end
            else
            begin
                if (item.first_byte)
                begin
                    word_begin_next = text_pos_reg;
                end
                still_next = still_reg && !item.force_miss
                             && bytes_alike(pattern_byte, item.char_code);
            end
        end
        else if (advance && item.is_end)
        begin
            out_valid_next  = 1'b1;
            found_next      = any_closed;
            total_next      = count_closed;
            start_next      = any_closed ? FIELD_BITS'(first_closed) : '0;
            // clear the scan state for the next text
            text_pos_next   = '0;
            word_begin_next = '0;
            first_hit_next  = '0;
            hit_count_next  = '0;
            still_next      = 1'b1;
            any_hit_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_pos_reg   <= '0;
            word_begin_reg <= '0;
            first_hit_reg  <= '0;
            hit_count_reg  <= '0;
            still_reg      <= 1'b1;
            any_hit_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            text_pos_reg   <= text_pos_next;
            word_begin_reg <= word_begin_next;
            first_hit_reg  <= first_hit_next;
            hit_count_reg  <= hit_count_next;
            still_reg      <= still_next;
            any_hit_reg    <= any_hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        total_reg <= total_next;
        start_reg <= start_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_total = total_reg;
    assign first_start = start_reg;

endmodule

>>> design/whole_word_match_counter.sv
// ----------------------------------------------------------------------------
// whole_word_match_counter
// Counts whole-word, loosely case-folded matches of a stored pattern word in a
// byte stream and reports the start of the first match.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle. A text byte reads the pattern
// store at the current word length as it is accepted; the next cycle compares
// the registered store byte and updates the match state, so the scan runs two
// stages deep with no bubbles. An end item passes the stage register and, once
// no older result waits, the output register; input is held back only while
// an end item waits behind a result not yet taken. pattern_length is at
// byte address 0 of the configuration port. The pattern store has no reset.
// ----------------------------------------------------------------------------
module whole_word_match_counter
    import wwmc_pkg::*;
#(
    parameter int MAX_WORD      = MAX_WORD_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [4:0]            pattern_slot,
    input  logic [7:0]            char_code,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  found,
    output logic [FIELD_BITS-1:0] match_total,
    output logic [FIELD_BITS-1:0] first_start
);

    localparam int WLW = $clog2(MAX_WORD + 1);
    localparam int AW  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

    logic [PLEN_BITS-1:0] plen_reg,     plen_next;
    logic [WLW-1:0]       wl_reg,       wl_next;
    logic                 s1_valid_reg, s1_valid_next;
    scan_item_t           s1_item_reg,  s1_item_next;

    logic       cfg_write;
    logic       accept;
    logic       is_load;
    logic       is_text;
    logic       is_end;
    logic       is_space;
    logic       mem_wr_en;
    logic [7:0] mem_rd_data;
    logic       scan_hold;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_PATTERN_LENGTH);
    assign prdata    = (paddr[2] == REG_PATTERN_LENGTH) ? 32'(plen_reg) : '0;
    assign plen_next = cfg_write ? pwdata[PLEN_BITS-1:0] : plen_reg;

    assign in_ready = !(s1_valid_reg && scan_hold);
    assign accept   = in_valid && in_ready;
    assign is_load  = (action == ACT_LOAD);
    assign is_text  = (action == ACT_TEXT);
    assign is_end   = (action == ACT_END);
    assign is_space = (char_code == SPACE_CHAR);

    assign mem_wr_en = accept && is_load && (32'(pattern_slot) < MAX_WORD);

    always_comb
    begin
        wl_next = wl_reg;
        if (accept && is_text)
        begin
            if (is_space)
            begin
                wl_next = '0;
            end
            else if (32'(wl_reg) < MAX_WORD)
            begin
                wl_next = wl_reg + 1'b1;
            end
        end
        else if (accept && is_end)
        begin
            wl_next = '0;
        end

        s1_item_next.is_text    = is_text;
        s1_item_next.is_end     = is_end;
        s1_item_next.first_byte = (wl_reg == '0);
        s1_item_next.force_miss = (32'(wl_reg) >= MAX_WORD)
                                  || (32'(wl_reg) >= 32'(plen_reg));
        s1_item_next.len_ok     = (wl_reg != '0) && (32'(wl_reg) == 32'(plen_reg))
                                  && (32'(plen_reg) <= MAX_WORD);
        s1_item_next.char_code  = char_code;

        // loads and unused codes finish here
        if (accept)
        begin
            s1_valid_next = is_text || is_end;
        end
        else if (!scan_hold)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg     <= PLEN_RESET;
            wl_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            plen_reg     <= plen_next;
            wl_reg       <= wl_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    wwmc_pattern_mem #(
        .DEPTH (MAX_WORD),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (AW'(pattern_slot)),
        .wr_data (char_code),
        .rd_en   (accept && is_text),
        .rd_addr (AW'(wl_reg)),
        .rd_data (mem_rd_data)
    );

    wwmc_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (s1_valid_reg),
        .item         (s1_item_reg),
        .pattern_byte (mem_rd_data),
        .hold         (scan_hold),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .match_total  (match_total),
        .first_start  (first_start)
    );

endmodule
